[rtl/ist_pkg.sv]
// Shared definitions for the integer set table: command codes, result word
// layout and default sizes. No dependencies.
package ist_pkg;

    // Default sizes handed to the top level parameters
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Command codes carried in s_tuser; code 7 is a no-op
    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_LOOKUP = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_MARK   = 3'd4,
        CMD_KEEP   = 3'd5,
        CMD_READ   = 3'd6
    } ist_cmd_t;

    // One result word, handed from the sequencer to the output register
    typedef struct packed {
        logic        read_valid;
        logic [31:0] read_value;
        logic        overflow;
        logic [6:0]  element_count;
        logic        present;
    } ist_result_t;

endpackage

[rtl/ist_ram.sv]
// Entry store of the integer set table: single-port-write, single-port-read
// synchronous RAM with a registered read port. No dependencies.
module ist_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 33
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ist_ctrl.sv]
// Command sequencer of the integer set table: scans, shifts and compacts the
// entry RAM one entry per cycle. Depends on ist_pkg and drives ist_ram.
module ist_ctrl #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // command side
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  logic [2:0]                  cmd,
    input  logic [VALUE_WIDTH-1:0]      value,
    input  logic [5:0]                  position,
    // result side
    output logic                        res_valid,
    input  logic                        res_ready,
    output ist_pkg::ist_result_t        res,
    // RAM port, word is {mark, value}
    output logic                        rd_en,
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  logic [VALUE_WIDTH:0]        rd_data,
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output logic [VALUE_WIDTH:0]        wr_data
);
    import ist_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CEW = (CW > 7) ? CW : 7;
    localparam int VEW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_SHIFT,
        ST_COMPACT,
        ST_RDWAIT,
        ST_RESP
    } state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             cmd_reg, cmd_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [5:0]             pos_reg, pos_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]          cmp_reg, cmp_next;
    logic                   pend_reg, pend_next;
    logic                   present_reg, present_next;
    logic                   overflow_reg, overflow_next;
    logic [31:0]            rval_reg, rval_next;
    logic                   rvalid_reg, rvalid_next;

    logic                   hit;
    logic                   pos_fits;
    logic [VEW-1:0]         rd_ext;
    logic [CEW-1:0]         count_ext;

    // A read issued last cycle matches the operand
    assign hit      = pend_reg && (rd_data[VALUE_WIDTH-1:0] == val_reg);
    assign pos_fits = 32'(pos_reg) < 32'(count_reg);
    assign rd_ext   = VEW'(rd_data[VALUE_WIDTH-1:0]);
    assign count_ext = CEW'(count_reg);

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);

    always_comb begin
        res.present       = present_reg;
        res.element_count = count_ext[6:0];
        res.overflow      = overflow_reg;
        res.read_value    = rval_reg;
        res.read_valid    = rvalid_reg;
    end

    // Next-state and RAM access logic
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        cmp_next      = cmp_reg;
        pend_next     = pend_reg;
        present_next  = present_reg;
        overflow_next = overflow_reg;
        rval_next     = rval_reg;
        rvalid_next   = rvalid_reg;
        rd_en         = 1'b0;
        rd_addr       = rd_ptr_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = wr_ptr_reg[AW-1:0];
        wr_data       = rd_data;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_next   = cmd;
                    val_next   = value;
                    pos_next   = position;
                    state_next = ST_START;
                end
            end

            ST_START: begin
                present_next  = 1'b0;
                overflow_next = 1'b0;
                rval_next     = '0;
                rvalid_next   = 1'b0;
                rd_ptr_next   = '0;
                wr_ptr_next   = '0;
                pend_next     = 1'b0;
                case (cmd_reg)
                    CMD_INSERT, CMD_REMOVE, CMD_LOOKUP, CMD_MARK: begin
                        state_next = ST_SCAN;
                    end
                    CMD_CLEAR: begin
                        count_next = '0;
                        state_next = ST_RESP;
                    end
                    CMD_KEEP: begin
                        state_next = ST_COMPACT;
                    end
                    CMD_READ: begin
                        if (pos_fits) begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(32'(pos_reg));
                            state_next = ST_RDWAIT;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            // Linear search, one read issued and one compare per cycle
            ST_SCAN: begin
                if (hit) begin
                    present_next = 1'b1;
                    pend_next    = 1'b0;
                    case (cmd_reg)
                        CMD_REMOVE: begin
                            rd_ptr_next = cmp_reg + ONE_C;
                            wr_ptr_next = cmp_reg;
                            state_next  = ST_SHIFT;
                        end
                        CMD_MARK: begin
                            wr_en      = 1'b1;
                            wr_addr    = cmp_reg[AW-1:0];
                            wr_data    = {1'b1, val_reg};
                            state_next = ST_RESP;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end else if (rd_ptr_reg < count_reg) begin
                    rd_en       = 1'b1;
                    pend_next   = 1'b1;
                    cmp_next    = rd_ptr_reg;
                    rd_ptr_next = rd_ptr_reg + ONE_C;
                end else begin
                    // not found
                    pend_next = 1'b0;
                    if (cmd_reg == CMD_INSERT) begin
                        if (count_reg == CAP_C) begin
                            overflow_next = 1'b1;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = {1'b0, val_reg};
                            count_next = count_reg + ONE_C;
                        end
                    end
                    state_next = ST_RESP;
                end
            end

            // Close the gap: read entry i+1, write it to i in the next cycle
            ST_SHIFT: begin
                if (pend_reg) begin
                    wr_en       = 1'b1;
                    wr_data     = rd_data;
                    wr_ptr_next = wr_ptr_reg + ONE_C;
                end
                if (rd_ptr_reg < count_reg) begin
                    rd_en       = 1'b1;
                    pend_next   = 1'b1;
                    rd_ptr_next = rd_ptr_reg + ONE_C;
                end else begin
                    pend_next  = 1'b0;
                    count_next = count_reg - ONE_C;
                    state_next = ST_RESP;
                end
            end

            // Keep marked entries in order, clearing their marks
            ST_COMPACT: begin
                if (pend_reg && rd_data[VALUE_WIDTH]) begin
                    wr_en       = 1'b1;
                    wr_data     = {1'b0, rd_data[VALUE_WIDTH-1:0]};
                    wr_ptr_next = wr_ptr_reg + ONE_C;
                end
                if (rd_ptr_reg < count_reg) begin
                    rd_en       = 1'b1;
                    pend_next   = 1'b1;
                    rd_ptr_next = rd_ptr_reg + ONE_C;
                end else begin
                    pend_next  = 1'b0;
                    count_next = wr_ptr_next;
                    state_next = ST_RESP;
                end
            end

            ST_RDWAIT: begin
                rvalid_next = 1'b1;
                rval_next   = rd_ext[31:0];
                state_next  = ST_RESP;
            end

            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        cmd_reg      <= cmd_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        rd_ptr_reg   <= rd_ptr_next;
        wr_ptr_reg   <= wr_ptr_next;
        cmp_reg      <= cmp_next;
        present_reg  <= present_next;
        overflow_reg <= overflow_next;
        rval_reg     <= rval_next;
        rvalid_reg   <= rvalid_next;
    end

endmodule

[rtl/integer_set_table_top.sv]
// Top level of the integer set table: stream ports, word packing and the
// output register. Depends on ist_pkg, ist_ctrl and ist_ram.

// A set of distinct integers kept in insertion order in a RAM of CAPACITY
// words (value plus mark bit). One command word in gives one result word out.
// Insert, remove, lookup and mark search the RAM linearly at one entry per
// cycle through its single read port; a remove that hits then shifts the
// later entries down. Keep-marked sweeps the whole set. A read inside the
// set fetches its entry from the RAM; a read at or beyond the count, clear
// and the no-op code do without a RAM read. Commands are taken one at a
// time; the next command word is accepted once the previous result sits
// in the output register, even if that word has not yet been taken
// downstream.
module integer_set_table_top #(
    parameter int CAPACITY    = ist_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ist_pkg::VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // value[31:0], position[37:32], zero fill
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // present[0], element_count[7:1], overflow[8],
                                   // read_value[40:9], read_valid[41], zero fill
);
    import ist_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int VEW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

    logic [VEW-1:0]         val_ext;
    logic [VALUE_WIDTH-1:0] val_in;
    logic                   res_valid;
    logic                   res_ready;
    ist_result_t            res;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH:0]   rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH:0]   wr_data;
    logic                   m_tvalid_reg;
    logic [47:0]            m_tdata_reg;

    // Stored value is the low VALUE_WIDTH bits of the 32-bit operand
    assign val_ext = VEW'(s_tdata[31:0]);
    assign val_in  = val_ext[VALUE_WIDTH-1:0];

    ist_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (s_tuser),
        .value     (val_in),
        .position  (s_tdata[37:32]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    ist_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH + 1)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Output register: free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {6'd0, res.read_valid, res.read_value, res.overflow,
                            res.element_count, res.present};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[tb/integer_set_table_top_tb.sv]
// Self-checking testbench for integer_set_table_top: a directed table, then random
// command sequences, checked word by word against the table's expected words or a behavioural set model.
// Depends on ist_pkg and the integer_set_table_top RTL.
module integer_set_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ist_pkg::*;

    localparam int SET_DEPTH    = CAPACITY_DEF;
    localparam int N_DIR        = 24;
    localparam int TOTAL_WORDS  = N_DIR + 600;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 2 * SET_DEPTH + 16;
    localparam int POOL_SIZE    = 48;

    // code 7 has no member in the package enum; the block treats it as a no-op
    localparam logic [2:0] CMD_NOP = 3'd7;

    typedef enum {PH_FILL, PH_CHURN, PH_INTERSECT, PH_READS} phase_t;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] val;
        logic [5:0]  pos;
        bit          known;
        ist_result_t want;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // value[31:0], position[37:32], zero fill
    logic [2:0]  s_tuser  = '0;   // cmd[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // present[0], element_count[7:1], overflow[8],
                                  // read_value[40:9], read_valid[41], zero fill

    // model of the set contents
    logic [31:0] set_vals [SET_DEPTH];
    bit          set_marks [SET_DEPTH];
    int          set_count = 0;

    ist_result_t pending_results [$];
    logic [31:0] value_pool [POOL_SIZE];
    dir_row_t    dir_rows [N_DIR];

    int mismatches  = 0;
    int words_sent  = 0;
    int burst_left  = 0;
    int no_gap_left = 0;
    bit hold_req    = 1'b0;
    bit hold_served = 1'b0;

    integer_set_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one command to the model set and returns the result word it gives
    function automatic ist_result_t apply_command(logic [2:0] op, logic [31:0] val,
                                                  logic [5:0] pos);
        ist_result_t r;
        int slot;
        int kept;
        r = '0;
        slot = -1;
        for (int i = 0; i < set_count; i++) begin
            if (slot < 0 && set_vals[i] == val) slot = i;
        end
        case (op)
            CMD_INSERT: begin
                if (slot >= 0) begin
                    r.present = 1'b1;
                end else if (set_count >= SET_DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    set_vals[set_count] = val;
                    set_marks[set_count] = 1'b0;
                    set_count++;
                end
            end
            CMD_REMOVE: begin
                if (slot >= 0) begin
                    r.present = 1'b1;
                    // later entries and their marks close the gap
                    for (int i = slot; i + 1 < set_count; i++) begin
                        set_vals[i] = set_vals[i + 1];
                        set_marks[i] = set_marks[i + 1];
                    end
                    set_count--;
                    set_marks[set_count] = 1'b0;
                end
            end
            CMD_LOOKUP: r.present = (slot >= 0);
            CMD_CLEAR: begin
                set_count = 0;
                foreach (set_marks[i]) set_marks[i] = 1'b0;
            end
            CMD_MARK: begin
                if (slot >= 0) begin
                    r.present = 1'b1;
                    set_marks[slot] = 1'b1;
                end
            end
            CMD_KEEP: begin
                kept = 0;
                for (int i = 0; i < set_count; i++) begin
                    if (set_marks[i]) begin
                        set_vals[kept] = set_vals[i];
                        kept++;
                    end
                end
                set_count = kept;
                foreach (set_marks[i]) set_marks[i] = 1'b0;
            end
            CMD_READ: begin
                if (pos < set_count) begin
                    r.read_valid = 1'b1;
                    r.read_value = set_vals[pos];
                end
            end
            default: ;
        endcase
        r.element_count = set_count[6:0];
        return r;
    endfunction

    function automatic ist_result_t result_of(bit pres, int cnt, bit ovf,
                                              logic [31:0] rval, bit rvalid);
        ist_result_t r;
        r.present       = pres;
        r.element_count = cnt[6:0];
        r.overflow      = ovf;
        r.read_value    = rval;
        r.read_valid    = rvalid;
        return r;
    endfunction

    // Mostly values from a small pool so that hits are common
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 3) != 0) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    // Sender pacing: bursts of random length with random gaps
    task automatic pace();
        int gap;
        if (no_gap_left > 0) begin
            no_gap_left--;
            return;
        end
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Offers one command word; the expected result is queued before acceptance
    task automatic send_word(logic [2:0] op, logic [31:0] val, logic [5:0] pos,
                             bit known, ist_result_t want);
        ist_result_t predicted;
        predicted = apply_command(op, val, pos);
        pending_results.push_back(known ? want : predicted);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {10'd0, pos, val};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        pace();
    endtask

    task automatic send_cmd(logic [2:0] op, logic [31:0] val);
        send_word(op, val, 6'($urandom_range(0, 63)), 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Stimulus
    initial begin
        phase_t ph;
        int n;
        int pick;
        bit first_phase;
        bit mid_pause_done;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom();

        dir_rows = '{
            '{CMD_READ,   32'h0000_0000, 6'd0,  1'b1, result_of(0, 0, 0, 32'h0, 0)},
            '{CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b1, result_of(0, 0, 0, 32'h0, 0)},
            '{CMD_INSERT, 32'h8000_0000, 6'd0,  1'b1, result_of(0, 1, 0, 32'h0, 0)},
            '{CMD_INSERT, 32'h7FFF_FFFF, 6'd63, 1'b1, result_of(0, 2, 0, 32'h0, 0)},
            // insert of a value already held
            '{CMD_INSERT, 32'h8000_0000, 6'd0,  1'b1, result_of(1, 2, 0, 32'h0, 0)},
            '{CMD_READ,   32'hFFFF_FFFF, 6'd0,  1'b1, result_of(0, 2, 0, 32'h8000_0000, 1)},
            // read beyond the count
            '{CMD_READ,   32'h0000_0000, 6'd63, 1'b1, result_of(0, 2, 0, 32'h0, 0)},
            '{CMD_INSERT, 32'h0000_0000, 6'd21, 1'b0, '0},
            '{CMD_INSERT, 32'hFFFF_FFFF, 6'd42, 1'b0, '0},
            '{CMD_READ,   32'h5555_5555, 6'd3,  1'b0, '0},
            '{CMD_MARK,   32'h7FFF_FFFF, 6'd0,  1'b0, '0},
            // mark of an absent value
            '{CMD_MARK,   32'h1234_5678, 6'd0,  1'b0, '0},
            '{CMD_MARK,   32'hFFFF_FFFF, 6'd0,  1'b0, '0},
            // removal below a marked entry shifts its mark down
            '{CMD_REMOVE, 32'h0000_0000, 6'd0,  1'b0, '0},
            '{CMD_KEEP,   32'hAAAA_AAAA, 6'd63, 1'b0, '0},
            '{CMD_READ,   32'h0000_0000, 6'd0,  1'b0, '0},
            '{CMD_READ,   32'h0000_0000, 6'd1,  1'b0, '0},
            '{CMD_REMOVE, 32'h7FFF_FFFF, 6'd0,  1'b0, '0},
            // remove of an absent value
            '{CMD_REMOVE, 32'h7FFF_FFFF, 6'd0,  1'b0, '0},
            '{CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b0, '0},
            '{CMD_NOP,    32'hAAAA_AAAA, 6'd42, 1'b0, '0},
            '{CMD_CLEAR,  32'h5555_5555, 6'd21, 1'b1, result_of(0, 0, 0, 32'h0, 0)},
            '{CMD_READ,   32'h0000_0000, 6'd0,  1'b1, result_of(0, 0, 0, 32'h0, 0)},
            '{CMD_KEEP,   32'h0000_0000, 6'd0,  1'b1, result_of(0, 0, 0, 32'h0, 0)}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (dir_rows[k]) begin
            send_word(dir_rows[k].op, dir_rows[k].val, dir_rows[k].pos,
                      dir_rows[k].known, dir_rows[k].want);
        end
        wait_drained();

        // random command sequences, the first one filling the set past full
        first_phase = 1'b1;
        mid_pause_done = 1'b0;
        while (words_sent < TOTAL_WORDS) begin
            if (!hold_req && words_sent >= N_DIR + 250) begin
                // receiver holds off while words keep coming
                hold_req = 1'b1;
                no_gap_left = 24;
            end
            if (!mid_pause_done && words_sent >= N_DIR + 450) begin
                mid_pause_done = 1'b1;
                wait_drained();
            end

            pick = $urandom_range(0, 9);
            if (first_phase || pick < 2) ph = PH_FILL;
            else if (pick < 6) ph = PH_CHURN;
            else if (pick < 8) ph = PH_INTERSECT;
            else ph = PH_READS;
            first_phase = 1'b0;

            case (ph)
                PH_FILL: begin
                    n = (SET_DEPTH - set_count) + $urandom_range(1, 4);
                    repeat (n) begin
                        send_cmd(CMD_INSERT,
                                 ($urandom_range(0, 9) == 0) ? pick_value() : $urandom());
                    end
                end
                PH_CHURN: begin
                    repeat ($urandom_range(10, 40)) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 30) send_cmd(CMD_INSERT, pick_value());
                        else if (pick < 55) send_cmd(CMD_REMOVE, pick_value());
                        else if (pick < 68) send_cmd(CMD_LOOKUP, pick_value());
                        else if (pick < 82) send_cmd(CMD_READ, $urandom());
                        else if (pick < 93) send_cmd(CMD_MARK, pick_value());
                        else if (pick < 96) send_cmd(CMD_NOP, $urandom());
                        else if (pick < 98) send_cmd(CMD_KEEP, $urandom());
                        else send_cmd(CMD_CLEAR, $urandom());
                    end
                end
                PH_INTERSECT: begin
                    // marks for the second set, mostly hitting held entries, then keep
                    repeat ($urandom_range(1, 20)) begin
                        if (set_count > 0 && $urandom_range(0, 9) < 6)
                            send_cmd(CMD_MARK, set_vals[$urandom_range(0, set_count - 1)]);
                        else
                            send_cmd(CMD_MARK, pick_value());
                    end
                    send_cmd(CMD_KEEP, $urandom());
                end
                default: begin
                    repeat ($urandom_range(4, 16)) send_cmd(CMD_READ, $urandom());
                end
            endcase
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Receiver: changing ready pattern, plus one long hold-off on request
    initial begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_served) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_served = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result checker: each accepted result word against the oldest expectation
    always @(posedge aclk) begin
        ist_result_t got;
        ist_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = ist_result_t'(m_tdata[41:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                compare_field("present", 32'(want.present), 32'(got.present));
                compare_field("element_count", 32'(want.element_count),
                              32'(got.element_count));
                compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
                compare_field("read_value", want.read_value, got.read_value);
                compare_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
                compare_field("zero fill", 32'h0, 32'(m_tdata[47:42]));
            end
        end
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
